// ===== rtl/core/crcbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcbe_pkg
// Shared types, constants and the polynomial justify function for the
// programmable byte-wise CRC engine.
// ----------------------------------------------------------------------------
package crcbe_pkg;

   localparam int unsigned ResidueWidth = 32;
   localparam int unsigned ByteWidth    = 8;

   localparam logic [ResidueWidth-1:0] PolyResetValue = 32'h04C1_1DB7;

   typedef logic [ResidueWidth-1:0] residue_type;
   typedef logic [ByteWidth-1:0]    byte_type;

   typedef struct packed {
      byte_type    data_byte;
      logic        first_byte;
      residue_type seed_residue;
      logic        last_byte;
   } req_type;

   // Drop the top coefficient and left-justify the rest; degree zero gives zero.
   function automatic residue_type justify_poly(input residue_type raw);
      residue_type result;
      result = '0;
      for (int d = 1; d < ResidueWidth; d++) begin
         if (raw[d]) begin
            result = raw << (ResidueWidth - d);
         end
      end
      return result;
   endfunction

   localparam residue_type PolyResetJustified = justify_poly(PolyResetValue);

endpackage

// ===== rtl/core/crcbe_fold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcbe_fold
// Folds one byte into a left-justified residue, MSB first, eight unrolled
// shift-and-XOR steps against the justified polynomial.
// ----------------------------------------------------------------------------
module crcbe_fold (
   input  crcbe_pkg::residue_type residue_start,
   input  crcbe_pkg::byte_type    data_byte,
   input  crcbe_pkg::residue_type poly,
   output crcbe_pkg::residue_type residue_next
);
   import crcbe_pkg::*;

   always_comb begin
      residue_type res;
      logic        fb;
      res = residue_start;
      for (int k = ByteWidth - 1; k >= 0; k--) begin
         fb  = data_byte[k] ^ res[ResidueWidth-1];
         res = {res[ResidueWidth-2:0], 1'b0};
         if (fb) begin
            res = res ^ poly;
         end
      end
      residue_next = res;
   end

endmodule

// ===== rtl/core/programmable_crc_byte_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// programmable_crc_byte_engine_unit
// Byte-wise CRC engine with a programmable generator polynomial.
//
// Requests arrive on req_* (valid/ready): one data byte with start and end
// flags and a seed residue used on a start byte. Each request gives one
// response on rsp_*: the left-justified residue after that byte and the
// end-of-message flag.
// A request lands in an input register, is folded by an unrolled
// eight-step update, and the response sits in an output register.
// Throughput is one byte per cycle while the receiver does not stall,
// bounded by the residue feedback through the fold logic.
// csr_we/csr_wdata load the raw polynomial; its justified form is
// registered at the write. Write it only while the engine is empty.
// Reset loads polynomial 0x04C11DB7, clears the running residue and
// empties both registers. When the receiver stalls, the output register
// holds, the input register fills and then req_ready drops.
// ----------------------------------------------------------------------------
module programmable_crc_byte_engine_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  crcbe_pkg::byte_type    req_data_byte,
   input  logic                   req_first_byte,
   input  crcbe_pkg::residue_type req_seed_residue,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output crcbe_pkg::residue_type rsp_residue,
   output logic                   rsp_message_end,
   input  logic                   csr_we,
   input  crcbe_pkg::residue_type csr_wdata
);
   import crcbe_pkg::*;

   residue_type poly_ff;
   residue_type running_residue_ff, running_residue_in;
   req_type     req_ff;
   logic        req_valid_ff;
   logic        rsp_valid_ff;
   residue_type rsp_residue_ff;
   logic        rsp_message_end_ff;
   residue_type fold_start;
   logic        advance;
   logic        req_take;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign fold_start = req_ff.first_byte ? req_ff.seed_residue : running_residue_ff;

   crcbe_fold u_fold (
      .residue_start (fold_start),
      .data_byte     (req_ff.data_byte),
      .poly          (poly_ff),
      .residue_next  (running_residue_in)
   );

   // polynomial
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= PolyResetJustified;
      end else if (csr_we) begin
         poly_ff <= justify_poly(csr_wdata);
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= '{data_byte:    req_data_byte,
                     first_byte:   req_first_byte,
                     seed_residue: req_seed_residue,
                     last_byte:    req_last_byte};
      end
   end

   // running residue and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         running_residue_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (advance) begin
            running_residue_ff <= running_residue_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_residue_ff     <= running_residue_in;
         rsp_message_end_ff <= req_ff.last_byte;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_residue     = rsp_residue_ff;
   assign rsp_message_end = rsp_message_end_ff;

   // assertions
   a_ready_only_when_room: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (req_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("req_ready low without a full pipeline");

   a_residue_tracks_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> (running_residue_ff == rsp_residue_ff))
      else $error("running residue differs from delivered residue");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> (req_valid_ff && $stable(req_ff)))
      else $error("blocked input register changed");

   a_poly_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset && !$past(csr_we) |-> (poly_ff == PolyResetJustified))
      else $error("polynomial not at reset value after reset");

endmodule
